// ===== design/mme_pkg.sv =====
// Shared types and codes for the matrix multiply engine.
`timescale 1ns / 1ps

package mme_pkg;

   // Store geometry: 64 x 64 entries, addressed by row and column.
   localparam int IDX_W  = 6;
   localparam int DIM    = 64;
   localparam int ADDR_W = 2 * IDX_W;
   localparam int ELEM_W = 32;
   localparam int ACC_W  = 64;

   // Request function codes.
   localparam logic [1:0] FUNC_WRITE_A = 2'd0;
   localparam logic [1:0] FUNC_WRITE_B = 2'd1;
   localparam logic [1:0] FUNC_QUERY   = 2'd2;

   typedef struct packed {
      logic [1:0]              func;
      logic [IDX_W-1:0]        row;
      logic [IDX_W-1:0]        col;
      logic signed [ELEM_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] c_value;
      logic                    saturated;
   } rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic             load;     // capture query indices, clear the sum
      logic             finish;   // return the cleared sum at once
      logic             wr_a;
      logic             wr_b;
      logic             rd_en;    // read one term pair
      logic             rd_last;  // this term pair is the last one
      logic [IDX_W-1:0] k;
   } mme_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic done;
   } mme_status_type;

endpackage

// ===== design/matrix_multiply_engine_core.sv =====
// Top level of the matrix multiply engine: controller plus datapath.
//
//   Channel   Ports                      Handshake
//   request   start, busy, req_payload   taken at an edge with start high, busy low
//   result    rsp_valid, rsp_payload     one-cycle strobe, always taken
//
// A write of A or B leaves busy low.
// A query holds busy while the controller reads one term per cycle on the
// store read ports, then until the multiply and accumulate registers drain; a query
// outside the order holds busy until its cleared sum returns. The result strobe comes in the last busy cycle.
// Synchronous reset clears the controller and the pipeline marks; the stores
// need no clearing. The receiver cannot stall the block.
`timescale 1ns / 1ps

module matrix_multiply_engine_core #(
   parameter int ORDER = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mme_pkg::req_type req_payload,
   output logic             rsp_valid,
   output mme_pkg::rsp_type rsp_payload
);

   import mme_pkg::*;

   mme_cmd_type    cmd;
   mme_status_type status;

   mme_ctrl #(.ORDER(ORDER)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_payload (req_payload),
      .status      (status),
      .busy        (busy),
      .cmd         (cmd)
   );

   mme_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== design/mme_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mme_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read the array; read data is registered and lands in the cycle after the read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/mme_ctrl.sv =====
// Controller state machine: decodes requests and steps through the terms of a query.
`timescale 1ns / 1ps

module mme_ctrl #(
   parameter int ORDER = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  mme_pkg::req_type       req_payload,
   input  mme_pkg::mme_status_type status,
   output logic                   busy,
   output mme_pkg::mme_cmd_type   cmd
);

   import mme_pkg::*;

   localparam int TERMS   = (ORDER < DIM) ? ORDER : DIM;
   localparam int ORDER_W = $clog2(ORDER + 1);
   localparam int CMP_W   = (ORDER_W > IDX_W) ? ORDER_W : IDX_W;
   localparam logic [IDX_W-1:0] K_LAST = IDX_W'(TERMS - 1);
   localparam logic [CMP_W-1:0] ORDER_C = CMP_W'(ORDER);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_WAIT
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic             inside_order;
   logic             accept;

   assign accept       = start && (state_ff == ST_IDLE);
   assign inside_order = (CMP_W'(req_payload.row) < ORDER_C) &&
                         (CMP_W'(req_payload.col) < ORDER_C);

   // Decode the request and sequence the term reads.
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      cmd      = '0;
      cmd.k    = k_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_payload.func inside {FUNC_WRITE_A, FUNC_WRITE_B}) begin
                  cmd.wr_a = inside_order && (req_payload.func == FUNC_WRITE_A);
                  cmd.wr_b = inside_order && (req_payload.func == FUNC_WRITE_B);
               end else if (req_payload.func == FUNC_QUERY) begin
                  cmd.load = 1'b1;
                  k_in     = '0;
                  if (inside_order) begin
                     state_in = ST_RUN;
                  end else begin
                     cmd.finish = 1'b1;
                     state_in   = ST_WAIT;
                  end
               end
            end
         end
         ST_RUN: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_last = (k_ff == K_LAST);
            k_in        = k_ff + 1'b1;
            if (k_ff == K_LAST) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (status.done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and the term counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== design/mme_datapath.sv =====
// Datapath: element stores, multiplier and saturating accumulator.
`timescale 1ns / 1ps

module mme_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  mme_pkg::req_type        req_payload,
   input  mme_pkg::mme_cmd_type    cmd,
   output mme_pkg::mme_status_type status,
   output logic                    rsp_valid,
   output mme_pkg::rsp_type        rsp_payload
);

   import mme_pkg::*;

   logic [IDX_W-1:0]        row_ff, col_ff;
   logic [ADDR_W-1:0]       wr_addr, a_rd_addr, b_rd_addr;
   logic [ELEM_W-1:0]       a_data, b_data;
   logic                    rd_valid_ff, rd_last_ff;
   logic                    prod_valid_ff, prod_last_ff;
   logic signed [ACC_W-1:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                    sat_ff, sat_in;
   logic                    done_ff;

   // Add two Q32.32 values and clamp on signed overflow.
   function automatic logic [ACC_W:0] sat_add(input logic [ACC_W-1:0] acc,
                                              input logic [ACC_W-1:0] term);
      logic [ACC_W-1:0] sum;
      logic             ovf;
      sum = acc + term;
      ovf = (acc[ACC_W-1] == term[ACC_W-1]) && (sum[ACC_W-1] != acc[ACC_W-1]);
      if (ovf) begin
         sum = acc[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end
      return {ovf, sum};
   endfunction

   assign wr_addr   = {req_payload.row, req_payload.col};
   assign a_rd_addr = {row_ff, cmd.k};
   assign b_rd_addr = {cmd.k, col_ff};

   mme_ram #(.WIDTH(ELEM_W), .DEPTH(DIM * DIM)) u_a_store (
      .clock   (clock),
      .wr_en   (cmd.wr_a),
      .wr_addr (wr_addr),
      .wr_data (req_payload.value),
      .rd_en   (cmd.rd_en),
      .rd_addr (a_rd_addr),
      .rd_data (a_data)
   );

   mme_ram #(.WIDTH(ELEM_W), .DEPTH(DIM * DIM)) u_b_store (
      .clock   (clock),
      .wr_en   (cmd.wr_b),
      .wr_addr (wr_addr),
      .wr_data (req_payload.value),
      .rd_en   (cmd.rd_en),
      .rd_addr (b_rd_addr),
      .rd_data (b_data)
   );

   // Capture the query indices.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         row_ff <= req_payload.row;
         col_ff <= req_payload.col;
      end
   end

   // Multiply the term pair once the store data arrives.
   always_ff @(posedge clock) begin
      prod_ff <= $signed(a_data) * $signed(b_data);
   end

   // Advance the valid and last marks alongside the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff   <= 1'b0;
         rd_last_ff    <= 1'b0;
         prod_valid_ff <= 1'b0;
         prod_last_ff  <= 1'b0;
         done_ff       <= 1'b0;
      end else begin
         rd_valid_ff   <= cmd.rd_en;
         rd_last_ff    <= cmd.rd_last;
         prod_valid_ff <= rd_valid_ff;
         prod_last_ff  <= rd_last_ff;
         done_ff       <= (prod_valid_ff && prod_last_ff) || cmd.finish;
      end
   end

   // Clear on load, accumulate each product with a sticky overflow flag.
   always_comb begin
      logic [ACC_W:0] add_res;
      add_res = sat_add(acc_ff, prod_ff);
      acc_in  = acc_ff;
      sat_in  = sat_ff;
      if (cmd.load) begin
         acc_in = '0;
         sat_in = 1'b0;
      end else if (prod_valid_ff) begin
         acc_in = $signed(add_res[ACC_W-1:0]);
         sat_in = sat_ff | add_res[ACC_W];
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      sat_ff <= sat_in;
   end

   assign status.done           = done_ff;
   assign rsp_valid             = done_ff;
   assign rsp_payload.c_value   = acc_ff;
   assign rsp_payload.saturated = sat_ff;

endmodule

// ===== design/mme_checker.sv =====
// Port-level checks on the matrix multiply engine and their bind.
`timescale 1ns / 1ps

module mme_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input mme_pkg::req_type req_payload,
   input logic             rsp_valid,
   input mme_pkg::rsp_type rsp_payload
);

   import mme_pkg::*;

   logic accept;
   assign accept = start && !busy;

   // A query request raises busy once it is taken.
   assert property (@(posedge clock) disable iff (reset)
      accept && (req_payload.func == FUNC_QUERY) |=> busy)
      else $error("query request did not raise busy");

   // Write and unused requests finish in their own cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept && (req_payload.func != FUNC_QUERY) |=> !busy && !rsp_valid)
      else $error("non-query request left the block busy or gave a result");

   // A result only appears while a query is in progress.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe outside a query");

   // The result ends the query: strobe drops and the block frees up.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("query did not end after its result");

endmodule

bind matrix_multiply_engine_core mme_checker u_checker (.*);
